>>> rtl/dsort_pkg.sv
// Shared widths, constants and control types of the descending record sorter.
`timescale 1ns / 1ps
`default_nettype none

package dsort_pkg;

    // Field widths of one record and one result.
    localparam int KEY_W = 12;
    localparam int TAG_W = 6;

    // Default depth of the sorting chain.
    localparam int MAX_RECORDS_DEF = 64;

    // Register file: data width, address width and register map.
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;
    localparam logic REG_IDX_THRESHOLD = 1'b0;

    // Threshold after reset: 15.00 in hundredths.
    localparam logic [KEY_W-1:0] THRESHOLD_RESET = 12'd1500;

    // Per-cycle command broadcast along the chain of cells.
    typedef struct packed {
        logic insert;
        logic shift;
    } cell_ctrl_t;

    // Sequencer states, one-hot.
    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EMIT = 2'b10
    } dsort_state_t;

endpackage

`default_nettype wire

>>> rtl/dsort_in_if.sv
// Input channel carrying one record per beat.
`timescale 1ns / 1ps
`default_nettype none

interface dsort_in_if
    import dsort_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [KEY_W-1:0] score_key;
    logic [TAG_W-1:0] record_tag;
    logic             batch_last;

    modport source (output valid, output score_key, output record_tag, output batch_last,
                    input ready);
    modport sink   (input valid, input score_key, input record_tag, input batch_last,
                    output ready);
endinterface

`default_nettype wire

>>> rtl/dsort_out_if.sv
// Output channel carrying one sorted result per beat.
`timescale 1ns / 1ps
`default_nettype none

interface dsort_out_if
    import dsort_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [KEY_W-1:0] sorted_key;
    logic [TAG_W-1:0] sorted_tag;
    logic             above_threshold;
    logic             is_top;
    logic             run_last;

    modport source (output valid, output sorted_key, output sorted_tag,
                    output above_threshold, output is_top, output run_last,
                    input ready);
    modport sink   (input valid, input sorted_key, input sorted_tag,
                    input above_threshold, input is_top, input run_last,
                    output ready);
endinterface

`default_nettype wire

>>> rtl/dsort_regs.sv
// APB-style register file holding the score threshold.
`timescale 1ns / 1ps
`default_nettype none

module dsort_regs
    import dsort_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    output logic      [KEY_W-1:0]      threshold
);

    logic [KEY_W-1:0] threshold_reg;
    logic [KEY_W-1:0] threshold_next;
    logic             hit_threshold;

    // Registers sit on word boundaries; bit 2 selects the register.
    assign hit_threshold = (paddr[2] == REG_IDX_THRESHOLD);
    assign pready        = 1'b1;

    // The threshold is written in the access phase of a write.
    always_comb
    begin
        threshold_next = threshold_reg;
        if (psel && penable && pwrite && pready && hit_threshold)
        begin
            threshold_next = pwdata[KEY_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THRESHOLD_RESET;
        end
        else
        begin
            threshold_reg <= threshold_next;
        end
    end

    // Read data; addresses beyond the map read as zero.
    always_comb
    begin
        prdata = '0;
        if (hit_threshold)
        begin
            prdata = {{(APB_DATA_W-KEY_W){1'b0}}, threshold_reg};
        end
    end

    assign threshold = threshold_reg;

endmodule

`default_nettype wire

>>> rtl/dsort_cell.sv
// One cell of the insertion chain: holds a single record in sorted position.
`timescale 1ns / 1ps
`default_nettype none

module dsort_cell
    import dsort_pkg::*;
(
    input  wire logic             clk,
    input  wire cell_ctrl_t       ctrl,
    input  wire logic             occupied,
    input  wire logic [KEY_W-1:0] new_key,
    input  wire logic [TAG_W-1:0] new_tag,
    input  wire logic             left_gt,
    input  wire logic [KEY_W-1:0] left_key,
    input  wire logic [TAG_W-1:0] left_tag,
    input  wire logic [KEY_W-1:0] right_key,
    input  wire logic [TAG_W-1:0] right_tag,
    output logic                  gt,
    output logic      [KEY_W-1:0] key,
    output logic      [TAG_W-1:0] tag
);

    logic [KEY_W-1:0] key_reg;
    logic [KEY_W-1:0] key_next;
    logic [TAG_W-1:0] tag_reg;
    logic [TAG_W-1:0] tag_next;

    // The new record belongs at or before this cell when the cell is empty or
    // holds a strictly smaller key, so equal keys keep their load order.
    assign gt = !occupied || (key_reg < new_key);

    // Insert: the first cell that flags takes the new record and every cell
    // after it takes its left neighbour. Shift: the chain drains towards the head.
    always_comb
    begin
        key_next = key_reg;
        tag_next = tag_reg;
        if (ctrl.shift)
        begin
            key_next = right_key;
            tag_next = right_tag;
        end
        else if (ctrl.insert && gt)
        begin
            if (left_gt)
            begin
                key_next = left_key;
                tag_next = left_tag;
            end
            else
            begin
                key_next = new_key;
                tag_next = new_tag;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        tag_reg <= tag_next;
    end

    assign key = key_reg;
    assign tag = tag_reg;

endmodule

`default_nettype wire

>>> rtl/dsort_chain.sv
// Row of sorting cells with the neighbour wiring and occupancy decode.
`timescale 1ns / 1ps
`default_nettype none

module dsort_chain
    import dsort_pkg::*;
#(
    parameter int MAX_RECORDS = MAX_RECORDS_DEF,
    localparam int CNT_W = $clog2(MAX_RECORDS + 1)
)
(
    input  wire logic             clk,
    input  wire cell_ctrl_t       ctrl,
    input  wire logic [CNT_W-1:0] fill,
    input  wire logic [KEY_W-1:0] new_key,
    input  wire logic [TAG_W-1:0] new_tag,
    output logic      [KEY_W-1:0] head_key,
    output logic      [TAG_W-1:0] head_tag
);

    logic [KEY_W-1:0] keys [MAX_RECORDS];
    logic [TAG_W-1:0] tags [MAX_RECORDS];
    logic             gts  [MAX_RECORDS];

    for (genvar i = 0; i < MAX_RECORDS; i++)
    begin : g_cell
        logic             occ;
        logic             l_gt;
        logic [KEY_W-1:0] l_key;
        logic [TAG_W-1:0] l_tag;
        logic [KEY_W-1:0] r_key;
        logic [TAG_W-1:0] r_tag;

        // The first fill cells hold records.
        assign occ = (CNT_W'(i) < fill);

        // The head has no left neighbour; the tail refills from itself.
        if (i == 0)
        begin : g_head
            assign l_gt  = 1'b0;
            assign l_key = new_key;
            assign l_tag = new_tag;
        end
        else
        begin : g_body
            assign l_gt  = gts[i-1];
            assign l_key = keys[i-1];
            assign l_tag = tags[i-1];
        end

        if (i == MAX_RECORDS - 1)
        begin : g_tail
            assign r_key = keys[i];
            assign r_tag = tags[i];
        end
        else
        begin : g_inner
            assign r_key = keys[i+1];
            assign r_tag = tags[i+1];
        end

        dsort_cell u_cell (
            .clk       (clk),
            .ctrl      (ctrl),
            .occupied  (occ),
            .new_key   (new_key),
            .new_tag   (new_tag),
            .left_gt   (l_gt),
            .left_key  (l_key),
            .left_tag  (l_tag),
            .right_key (r_key),
            .right_tag (r_tag),
            .gt        (gts[i]),
            .key       (keys[i]),
            .tag       (tags[i])
        );
    end

    assign head_key = keys[0];
    assign head_tag = tags[0];

endmodule

`default_nettype wire

>>> rtl/descending_record_sorter_unit.sv
// Top level of the descending record sorter: sequencer, output register and registers.
//
// Usage: records arrive on the records channel, one per beat. Each accepted
// record is placed into a chain of MAX_RECORDS cells in the same cycle. A
// record that arrives while the chain is full is dropped. The beat marked
// batch_last ends the batch: from the next cycle the chain drains from its
// head, one result per cycle while the receiver is ready, in descending key
// order with ties in load order, the final one flagged by run_last. The
// first result is registered after the sequencer enters its drain state, and
// the rest follow at one per cycle while the receiver is ready; records is
// not ready while a batch drains, so a new batch waits for the drain to end.
// A stalled receiver holds the output register and freezes the drain.
// The next batch is accepted as soon as the final result is registered.
// Reset marks the chain empty, clears the output valid and sets the threshold to
// 15.00. The threshold register is at byte address 0 of the APB port.
`timescale 1ns / 1ps
`default_nettype none

module descending_record_sorter_unit
    import dsort_pkg::*;
#(
    parameter int MAX_RECORDS = MAX_RECORDS_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    dsort_in_if.sink                   records,
    dsort_out_if.source                results,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready
);

    localparam int CNT_W = $clog2(MAX_RECORDS + 1);
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(MAX_RECORDS);
    localparam logic [CNT_W-1:0] ONE_COUNT  = CNT_W'(1);

    dsort_state_t     state_reg, state_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic [CNT_W-1:0] rem_reg, rem_next;
    logic             first_reg, first_next;
    logic [KEY_W-1:0] top_reg, top_next;
    logic             out_valid_reg, out_valid_next;
    logic [KEY_W-1:0] out_key_reg;
    logic [TAG_W-1:0] out_tag_reg;
    logic             out_above_reg;
    logic             out_top_reg;
    logic             out_last_reg;

    logic             accept;
    logic             full;
    logic             load;
    logic [KEY_W-1:0] top_value;
    logic [KEY_W-1:0] head_key;
    logic [TAG_W-1:0] head_tag;
    logic [KEY_W-1:0] threshold;
    cell_ctrl_t       ctrl;

    // Register file.
    dsort_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .threshold (threshold)
    );

    // Handshake and chain commands.
    assign records.ready = (state_reg == ST_IDLE);
    assign accept        = records.valid && records.ready;
    assign full          = (fill_reg == FULL_COUNT);
    assign load          = (state_reg == ST_EMIT) && (!out_valid_reg || results.ready);
    assign ctrl.insert   = accept && !full;
    assign ctrl.shift    = load;

    // The batch maximum is the head key at the first result of the drain.
    assign top_value = first_reg ? head_key : top_reg;

    dsort_chain #(
        .MAX_RECORDS (MAX_RECORDS)
    ) u_chain (
        .clk      (clk),
        .ctrl     (ctrl),
        .fill     (fill_reg),
        .new_key  (records.score_key),
        .new_tag  (records.record_tag),
        .head_key (head_key),
        .head_tag (head_tag)
    );

    // Sequencer: load records until the last one, then drain the chain.
    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        rem_next       = rem_reg;
        first_next     = first_reg;
        top_next       = top_reg;
        out_valid_next = out_valid_reg;
        if (results.ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (records.batch_last)
                    begin
                        state_next = ST_EMIT;
                        rem_next   = full ? fill_reg : fill_reg + ONE_COUNT;
                        fill_next  = '0;
                        first_next = 1'b1;
                    end
                    else if (!full)
                    begin
                        fill_next = fill_reg + ONE_COUNT;
                    end
                end
            end
            ST_EMIT:
            begin
                if (load)
                begin
                    out_valid_next = 1'b1;
                    rem_next       = rem_reg - ONE_COUNT;
                    first_next     = 1'b0;
                    top_next       = top_value;
                    if (rem_reg == ONE_COUNT)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            rem_reg       <= '0;
            first_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            rem_reg       <= rem_next;
            first_reg     <= first_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload register, loaded from the chain head.
    always_ff @(posedge clk)
    begin
        top_reg <= top_next;
        if (load)
        begin
            out_key_reg   <= head_key;
            out_tag_reg   <= head_tag;
            out_above_reg <= (head_key > threshold);
            out_top_reg   <= (head_key == top_value);
            out_last_reg  <= (rem_reg == ONE_COUNT);
        end
    end

    assign results.valid           = out_valid_reg;
    assign results.sorted_key      = out_key_reg;
    assign results.sorted_tag      = out_tag_reg;
    assign results.above_threshold = out_above_reg;
    assign results.is_top          = out_top_reg;
    assign results.run_last        = out_last_reg;

    // The record count never passes the chain depth.
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FULL_COUNT)
        else $error("record count beyond chain depth");

    // A last beat starts a drain with at least one result pending.
    a_last_starts_drain: assert property (@(posedge clk) disable iff (!rst_n)
        accept && records.batch_last |=> (state_reg == ST_EMIT) && (rem_reg != '0))
        else $error("last record did not start a drain");

    // The final result of a drain returns the sequencer to loading.
    a_drain_end: assert property (@(posedge clk) disable iff (!rst_n)
        load && (rem_reg == ONE_COUNT) |=> (state_reg == ST_IDLE) && results.run_last)
        else $error("drain did not end on the final result");

    // The chain is logically empty while it drains.
    a_empty_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> (fill_reg == '0))
        else $error("records counted during a drain");

endmodule

`default_nettype wire

>>> bench/tb.sv
// Self-checking bench for the descending record sorter: stimulus, scoreboard and register access.
`timescale 1ns / 1ps

module tb
    import dsort_pkg::*;
();

    localparam int MAX_RECORDS = MAX_RECORDS_DEF;
    localparam int SETTLE_CYCLES = 12;
    localparam int STALL_LIMIT = 2000;

    // Register map: the threshold sits at index 0, the next index is unused.
    localparam logic [APB_ADDR_W-1:0] THRESHOLD_ADDR = APB_ADDR_W'(4 * REG_IDX_THRESHOLD);
    localparam logic [APB_ADDR_W-1:0] SPARE_ADDR = APB_ADDR_W'(4 * (REG_IDX_THRESHOLD + 1));

    typedef enum int {
        KEYS_ANY,
        KEYS_TIED,
        KEYS_RANGE,
        KEYS_NEAR
    } key_mix_t;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [TAG_W-1:0] tag;
        logic             last;
    } record_t;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [TAG_W-1:0] tag;
        logic             above;
        logic             top;
        logic             last;
    } ranked_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    // Bench-side drive of the block's inputs, known from time zero.
    logic                  in_valid = 1'b0;
    record_t               in_record = '0;
    logic                  out_ready = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // Sorted store of the loaded batch and the threshold as the bench sees them.
    logic [KEY_W-1:0] held_key [MAX_RECORDS];
    logic [TAG_W-1:0] held_tag [MAX_RECORDS];
    int               held_count = 0;
    logic [KEY_W-1:0] threshold_copy = THRESHOLD_RESET;

    record_t records_waiting [$];
    ranked_t ranked_due [$];
    int      mismatch_count = 0;
    logic    idling_on = 1'b1;
    int      gap_left = 0;
    int      stall_left = 0;
    int      quiet_cycles = 0;

    dsort_in_if  records_if ();
    dsort_out_if results_if ();

    assign records_if.valid      = in_valid;
    assign records_if.score_key  = in_record.key;
    assign records_if.record_tag = in_record.tag;
    assign records_if.batch_last = in_record.last;
    assign results_if.ready      = out_ready;

    descending_record_sorter_unit #(
        .MAX_RECORDS(MAX_RECORDS)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .records (records_if),
        .results (results_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Mostly short idle spells, now and then a long one, none while idling is off.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (!idling_on || roll < 50)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // Append one record to the queue of pending beats.
    function automatic void add_record(input record_t rec);
        records_waiting = {records_waiting, rec};
    endfunction

    // Insert one record behind every held key that is not smaller; a full store
    // drops it. A last record releases the whole store in descending order.
    function automatic void rank_record(input record_t rec);
        int      pos;
        ranked_t res;
        if (held_count < MAX_RECORDS)
        begin
            pos = 0;
            while (pos < held_count && held_key[pos] >= rec.key)
                pos++;
            for (int i = held_count; i > pos; i--)
            begin
                held_key[i] = held_key[i-1];
                held_tag[i] = held_tag[i-1];
            end
            held_key[pos] = rec.key;
            held_tag[pos] = rec.tag;
            held_count++;
        end
        if (rec.last)
        begin
            for (int i = 0; i < held_count; i++)
            begin
                res.key   = held_key[i];
                res.tag   = held_tag[i];
                res.above = held_key[i] > threshold_copy;
                res.top   = held_key[i] == held_key[0];
                res.last  = i == held_count - 1;
                ranked_due = {ranked_due, res};
            end
            held_count = 0;
        end
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endfunction

    // Record driver: each accepted beat goes through the predictor.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            gap_left <= 0;
        end
        else
        begin
            if (in_valid && records_if.ready)
                rank_record(in_record);
            if (!in_valid || records_if.ready)
            begin
                if (gap_left > 0)
                begin
                    in_valid <= 1'b0;
                    gap_left <= gap_left - 1;
                end
                else if (records_waiting.size() != 0)
                begin
                    in_record <= records_waiting.pop_front();
                    in_valid  <= 1'b1;
                    gap_left  <= pick_gap();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor with a randomly stalling receiver.
    always @(posedge clk or negedge rst_n)
    begin
        ranked_t want;
        if (!rst_n)
        begin
            out_ready  <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            if (results_if.valid && out_ready)
            begin
                if (ranked_due.size() == 0)
                begin
                    $error("result beat with nothing due: key %0d, tag %0d",
                           results_if.sorted_key, results_if.sorted_tag);
                    mismatch_count++;
                end
                else
                begin
                    want = ranked_due.pop_front();
                    check_field("sorted_key", want.key, results_if.sorted_key);
                    check_field("sorted_tag", want.tag, results_if.sorted_tag);
                    check_field("above_threshold", want.above, results_if.above_threshold);
                    check_field("is_top", want.top, results_if.is_top);
                    check_field("run_last", want.last, results_if.run_last);
                end
            end
            if (stall_left > 0)
            begin
                out_ready  <= 1'b0;
                stall_left <= stall_left - 1;
            end
            else
            begin
                out_ready  <= 1'b1;
                stall_left <= pick_gap();
            end
        end
    end

    // Watchdog: too long without any beat or register transfer ends the run.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && records_if.ready) || (results_if.valid && out_ready) || psel)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // One APB transfer; a read of the threshold is checked against the bench copy.
    task automatic access_register(input logic is_write, input logic [APB_ADDR_W-1:0] addr,
                                   input logic [APB_DATA_W-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (is_write && addr == THRESHOLD_ADDR)
            threshold_copy = value[KEY_W-1:0];
        if (!is_write && addr == THRESHOLD_ADDR)
            check_field("score_threshold", threshold_copy, prdata[KEY_W-1:0]);
    endtask

    function automatic logic [KEY_W-1:0] pick_key(input key_mix_t mix);
        logic [KEY_W-1:0] k;
        case (mix)
            KEYS_TIED:  k = ($urandom_range(0, 4) == 0) ? {KEY_W{1'b1}}
                                                        : KEY_W'(100 * $urandom_range(0, 3));
            KEYS_RANGE: k = KEY_W'($urandom_range(0, 3000));
            KEYS_NEAR:  k = threshold_copy + KEY_W'($urandom_range(0, 4)) - KEY_W'(2);
            default:    k = KEY_W'($urandom);
        endcase
        return k;
    endfunction

    task automatic queue_batch(input int count, input key_mix_t mix);
        record_t rec;
        for (int i = 0; i < count; i++)
        begin
            rec.key  = pick_key(mix);
            rec.tag  = TAG_W'($urandom);
            rec.last = i == count - 1;
            add_record(rec);
        end
    endtask

    // Batches of random size and key mix, mostly short.
    task automatic queue_random_batches(input int budget);
        int count;
        while (budget > 0)
        begin
            count = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 8) : $urandom_range(9, 24);
            queue_batch(count, key_mix_t'($urandom_range(0, 3)));
            budget -= count;
        end
    endtask

    // Wait until every batch has drained, then let the block settle.
    task automatic settle();
        while (records_waiting.size() != 0 || in_valid || ranked_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        access_register(1'b0, THRESHOLD_ADDR, '0);

        // Single records at the key and tag extremes, one above the range.
        add_record('{key: 12'd0, tag: 6'd0, last: 1'b1});
        add_record('{key: 12'hFFF, tag: 6'h3F, last: 1'b1});
        // Keys around the threshold with a tie to check load order.
        add_record('{key: 12'd1500, tag: 6'd1, last: 1'b0});
        add_record('{key: 12'd1501, tag: 6'd2, last: 1'b0});
        add_record('{key: 12'd1499, tag: 6'd3, last: 1'b0});
        add_record('{key: 12'd1500, tag: 6'd4, last: 1'b0});
        add_record('{key: 12'd3000, tag: 6'd5, last: 1'b0});
        add_record('{key: 12'd0, tag: 6'd6, last: 1'b1});
        // All keys equal: every result is the top one.
        add_record('{key: 12'd700, tag: 6'd10, last: 1'b0});
        add_record('{key: 12'd700, tag: 6'd11, last: 1'b0});
        add_record('{key: 12'd700, tag: 6'd12, last: 1'b1});
        // Ascending keys, mostly single-bit, which must come out reversed.
        add_record('{key: 12'd1, tag: 6'h15, last: 1'b0});
        add_record('{key: 12'd2, tag: 6'h2A, last: 1'b0});
        add_record('{key: 12'd1024, tag: 6'h20, last: 1'b0});
        add_record('{key: 12'd2048, tag: 6'h1F, last: 1'b0});
        add_record('{key: 12'd4094, tag: 6'h3E, last: 1'b1});
        settle();

        // Lowest threshold: every non-zero key is above it.
        access_register(1'b1, THRESHOLD_ADDR, 32'd0);
        access_register(1'b0, THRESHOLD_ADDR, '0);
        queue_random_batches(16);
        settle();

        // Highest threshold in range, with no idling on either side.
        access_register(1'b1, THRESHOLD_ADDR, 32'd3000);
        idling_on = 1'b0;
        queue_random_batches(16);
        settle();
        idling_on = 1'b1;

        // All-ones threshold: no key is above it.
        access_register(1'b1, THRESHOLD_ADDR, 32'hFFFF_FFFF);
        access_register(1'b0, THRESHOLD_ADDR, '0);
        queue_random_batches(16);
        settle();

        // A write to an unused index must leave the threshold alone.
        access_register(1'b1, SPARE_ADDR, 32'h0000_0123);
        access_register(1'b0, THRESHOLD_ADDR, '0);
        // Upper data bits are dropped; then overflow the store so the last two
        // records, the one marked last among them, are discarded.
        access_register(1'b1, THRESHOLD_ADDR, 32'hABCD_E0C8);
        queue_batch(MAX_RECORDS + 2, KEYS_TIED);
        settle();

        access_register(1'b1, THRESHOLD_ADDR, APB_DATA_W'($urandom_range(0, 3000)));
        access_register(1'b0, THRESHOLD_ADDR, '0);
        queue_random_batches(12);
        settle();

        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
